// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define LAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lux converter assertion failed");

// Next-cycle implication, off while reset is held.
`define LAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lux converter assertion failed");

`endif

// ----- rtl/lac_pkg.sv -----
package lac_pkg;

    // Field widths.
    localparam int COUNT_W   = 16;
    localparam int SETTING_W = 8;
    localparam int LUX_W     = 22;
    localparam int CNT_W     = 3;

    // Lux arithmetic widths: dividend, divisor and divider step counter.
    localparam int NUM_W     = 37;
    localparam int DEN_W     = 31;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);

    // Autorange constants.
    localparam logic [CNT_W-1:0]     MAX_RAISES          = 3'd6;
    localparam logic [SETTING_W-1:0] SETTING_RESET       = 8'd218;
    localparam logic [SETTING_W-1:0] SETTING_CLAMP_ABOVE = 8'd250;
    localparam logic [LUX_W-1:0]     LUX_MAX             = '1;

    // Configuration reset values.
    localparam logic [15:0] RST_RAISE_THRESHOLD = 16'd50000;
    localparam logic [7:0]  RST_SETTING_MAX     = 8'd250;
    localparam logic [5:0]  RST_CLOCK_PERIOD    = 6'd28;
    localparam logic [1:0]  RST_GAIN_CODE       = 2'd0;

    // Scale factors for the ratio test and the clock; the lux scale (102.6 * 10) is applied as shifts in the datapath.
    localparam logic [6:0]  RATIO_SCALE = 7'd100;
    localparam logic [15:0] CLK_SCALE   = 16'd964;

    // Ratio bands, scaled by 100, and their coefficient pairs, scaled by 1000.
    localparam logic [7:0]  BAND_LIMIT [4] = '{8'd26, 8'd55, 8'd109, 8'd213};
    localparam logic [11:0] COEF_VIS   [4] = '{12'd1290, 12'd795, 12'd510, 12'd276};
    localparam logic [11:0] COEF_IR    [4] = '{12'd2733, 12'd859, 12'd345, 12'd130};

    // Gains 1, 2, 64 and 128 as left shifts.
    localparam logic [2:0]  GAIN_SHIFT [4] = '{3'd0, 3'd1, 3'd6, 3'd7};

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_RAISE = 2'd0,
        STATUS_LUX   = 2'd1,
        STATUS_ERROR = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_RAISE_THRESHOLD = 2'd0,
        CFG_SETTING_MAX     = 2'd1,
        CFG_CLOCK_PERIOD    = 2'd2,
        CFG_GAIN_CODE       = 2'd3
    } t_cfg_index;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic product;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic read_fail;
        logic raise;
        logic lux_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/lac_ctrl.sv -----
module lac_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    input  lac_pkg::t_dp_status i_status,
    output lac_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_EVAL    = 5'b00010,
        ST_PRODUCT = 5'b00100,
        ST_DIVIDE  = 5'b01000,
        ST_EMIT    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_ready = (r_state == ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.read_fail || i_status.raise) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PRODUCT;
                end
            end
            ST_PRODUCT: begin
                o_cmd.product = 1'b1;
                n_state       = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                // A result known to be zero skips the divider.
                if (i_status.lux_zero) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_status.div_done) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/lac_datapath.sv -----
module lac_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    input  logic [15:0]         i_visible_count,
    input  logic [15:0]         i_infrared_count,
    input  logic                i_read_ok,
    input  lac_pkg::t_dp_cmd    i_cmd,
    output lac_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status_code,
    output logic [7:0]          o_next_setting,
    output logic [21:0]         o_lux
);

    // Configuration registers.
    logic [15:0] r_thr;
    logic [7:0]  r_smax;
    logic [5:0]  r_tper;
    logic [1:0]  r_gain;

    // Autorange state.
    logic [7:0] r_cur;
    logic [2:0] r_cnt;

    // Captured reading.
    logic [15:0] r_d0;
    logic [15:0] r_d1;
    logic        r_ok;

    // Evaluation results.
    lac_pkg::t_status r_kind;
    logic [1:0]       r_band;
    logic             r_lux_zero;
    logic [15:0]      r_t964;

    // Division operands and state.
    logic                          r_pos_gt;
    logic [lac_pkg::NUM_W-1:0]     r_num;
    logic [lac_pkg::DEN_W-1:0]     r_den;
    logic [lac_pkg::DEN_W-1:0]     r_rem;
    logic [lac_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_setting;
    logic [21:0] r_out_lux;

    logic        raise_req;
    logic [22:0] ir_scaled;
    logic [3:0]  band_hit;
    logic [1:0]  band_idx;
    logic        band_none;
    logic        zero_cnt;
    logic [27:0] pos;
    logic [27:0] neg;
    logic [26:0] diff;
    logic [lac_pkg::NUM_W-1:0] num;
    logic [8:0]  span;
    logic [24:0] den_base;
    logic [lac_pkg::DEN_W-1:0] den;
    logic [lac_pkg::DEN_W:0]   trial;
    logic        trial_ge;
    logic [7:0]  gap;
    logic [8:0]  raise_sum;
    logic [7:0]  raise_next;
    logic [21:0] lux_val;

    // Raise decision on the captured reading.
    assign raise_req = ((r_d0 > r_thr) || (r_d1 > r_thr)) && (r_cnt < lac_pkg::MAX_RAISES);
    assign zero_cnt  = (r_d0 == '0) || (r_d1 == '0);

    // Ratio band by cross-multiplication against each limit.
    assign ir_scaled = 23'(r_d1) * 23'(lac_pkg::RATIO_SCALE);
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            band_hit[b] = {1'b0, ir_scaled} < (24'(r_d0) * 24'(lac_pkg::BAND_LIMIT[b]));
        end
        band_idx  = 2'd0;
        band_none = 1'b1;
        for (int b = 3; b >= 0; b--) begin
            if (band_hit[b]) begin
                band_idx  = 2'(b);
                band_none = 1'b0;
            end
        end
    end

    // Numerator: coefficient difference times 1026; denominator without gain first.
    assign pos      = 28'(r_d0) * 28'(lac_pkg::COEF_VIS[r_band]);
    assign neg      = 28'(r_d1) * 28'(lac_pkg::COEF_IR[r_band]);
    assign diff     = 27'(pos - neg);
    assign num      = (lac_pkg::NUM_W'(diff) << 10) + (lac_pkg::NUM_W'(diff) << 1);
    assign span     = 9'd256 - 9'(r_cur);
    assign den_base = 25'(r_t964) * 25'(span);
    assign den      = lac_pkg::DEN_W'(den_base) << lac_pkg::GAIN_SHIFT[r_gain];

    // One restoring division step per cycle.
    assign trial    = {r_rem, r_num[lac_pkg::NUM_W-1]};
    assign trial_ge = trial >= {1'b0, r_den};

    // Raised setting: half the gap to the maximum plus one, clamped.
    always_comb begin
        gap = '0;
        if (r_smax > r_cur) begin
            gap = (r_smax - r_cur) >> 1;
        end
        raise_sum  = 9'(r_cur) + 9'(gap) + 9'd1;
        raise_next = raise_sum[7:0];
        if (raise_next > lac_pkg::SETTING_CLAMP_ABOVE) begin
            raise_next = r_smax;
        end
    end

    // Final lux with saturation.
    always_comb begin
        if (r_lux_zero || !r_pos_gt) begin
            lux_val = '0;
        end else if (|r_num[lac_pkg::NUM_W-1:lac_pkg::LUX_W]) begin
            lux_val = lac_pkg::LUX_MAX;
        end else begin
            lux_val = r_num[lac_pkg::LUX_W-1:0];
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.read_fail = !r_ok;
        o_status.raise     = raise_req;
        o_status.lux_zero  = r_lux_zero || !r_pos_gt;
        o_status.div_done  = (r_div_cnt == lac_pkg::DIV_LAST);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // Configuration, autorange state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= lac_pkg::RST_RAISE_THRESHOLD;
            r_smax      <= lac_pkg::RST_SETTING_MAX;
            r_tper      <= lac_pkg::RST_CLOCK_PERIOD;
            r_gain      <= lac_pkg::RST_GAIN_CODE;
            r_cur       <= lac_pkg::SETTING_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (lac_pkg::t_cfg_index'(i_cfg_index))
                    lac_pkg::CFG_RAISE_THRESHOLD: r_thr  <= i_cfg_wdata;
                    lac_pkg::CFG_SETTING_MAX:     r_smax <= i_cfg_wdata[7:0];
                    lac_pkg::CFG_CLOCK_PERIOD:    r_tper <= i_cfg_wdata[5:0];
                    lac_pkg::CFG_GAIN_CODE:       r_gain <= i_cfg_wdata[1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_kind == lac_pkg::STATUS_RAISE) begin
                    r_cur <= raise_next;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_cur <= lac_pkg::SETTING_RESET;
                    r_cnt <= '0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: reading, evaluation, division and output fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d0 <= i_visible_count;
            r_d1 <= i_infrared_count;
            r_ok <= i_read_ok;
        end
        if (i_cmd.eval) begin
            if (!r_ok) begin
                r_kind <= lac_pkg::STATUS_ERROR;
            end else if (raise_req) begin
                r_kind <= lac_pkg::STATUS_RAISE;
            end else begin
                r_kind <= lac_pkg::STATUS_LUX;
            end
            r_band     <= band_idx;
            r_lux_zero <= zero_cnt || band_none;
            r_t964     <= 16'(r_tper) * lac_pkg::CLK_SCALE;
        end
        if (i_cmd.product) begin
            r_pos_gt  <= pos > neg;
            r_num     <= num;
            r_den     <= den;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= trial_ge ? lac_pkg::DEN_W'(trial - {1'b0, r_den})
                                  : trial[lac_pkg::DEN_W-1:0];
            r_num     <= {r_num[lac_pkg::NUM_W-2:0], trial_ge};
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_kind;
            case (r_kind)
                lac_pkg::STATUS_RAISE: begin
                    r_out_setting <= raise_next;
                    r_out_lux     <= '0;
                end
                lac_pkg::STATUS_LUX: begin
                    r_out_setting <= lac_pkg::SETTING_RESET;
                    r_out_lux     <= lux_val;
                end
                default: begin
                    r_out_setting <= lac_pkg::SETTING_RESET;
                    r_out_lux     <= '0;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status_code  = r_out_status;
    assign o_next_setting = r_out_setting;
    assign o_lux          = r_out_lux;

endmodule

// ----- rtl/lux_autorange_converter_top.sv -----
// Lux converter with integration-time autorange for a two-channel light sensor.
// Input stream: one completed reading per item. Output stream: one result per
// item, either a request for a new reading at a raised setting, a final lux
// value, or an error for a failed reading. Configuration registers are written
// through i_cfg_we/i_cfg_index/i_cfg_wdata; the user must do so only while no
// item is in flight, as the block does not enforce it. A raise or an error goes
// from evaluation straight to the output register; a lux known to be zero skips
// the divider; a computed lux passes the product and the 37-step restoring
// divider, one quotient bit per cycle. An item is accepted once the previous
// one has been handed to the output register, so readings are taken one at a time.
// A finished result waits in the output register while the next item is
// already accepted and processed; if the receiver still stalls when that next
// result is ready, the block holds it and takes no new item.
// Reset clears the configuration to its defaults, the setting to 218, the
// raise count to zero, and drops any pending result.
module lux_autorange_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // Reading stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] visible_count, [31:16] infrared_count
    input  logic        s_axis_tuser,  // [0] read_ok
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [1:0] status, [9:2] next_setting, [31:10] lux
);

    lac_pkg::t_dp_cmd    dp_cmd;
    lac_pkg::t_dp_status dp_status;
    logic [1:0]          out_status;
    logic [7:0]          out_setting;
    logic [21:0]         out_lux;

    lac_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    lac_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_visible_count  (s_axis_tdata[15:0]),
        .i_infrared_count (s_axis_tdata[31:16]),
        .i_read_ok        (s_axis_tuser),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_status_code    (out_status),
        .o_next_setting   (out_setting),
        .o_lux            (out_lux)
    );

    assign m_axis_tdata = {out_lux, out_setting, out_status};

endmodule

// ----- rtl/lac_checker.sv -----
`include "assert_macros.svh"

module lac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_valid,
    input logic        i_s_ready,
    input logic        i_m_valid,
    input logic [31:0] i_m_data
);

    // Only the three defined status codes appear.
    `LAC_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, i_m_valid, (i_m_data[1:0] == lac_pkg::STATUS_RAISE) || (i_m_data[1:0] == lac_pkg::STATUS_LUX) || (i_m_data[1:0] == lac_pkg::STATUS_ERROR))

    // Lux is zero unless the result is a final lux.
    `LAC_ASSERT_IMPL(a_lux_only_final, i_clk, i_rst_n, i_m_valid && (i_m_data[1:0] != lac_pkg::STATUS_LUX), i_m_data[31:10] == '0)

    // Final and error results send the setting back to its reset value.
    `LAC_ASSERT_IMPL(a_setting_back, i_clk, i_rst_n, i_m_valid && (i_m_data[1:0] != lac_pkg::STATUS_RAISE), i_m_data[9:2] == lac_pkg::SETTING_RESET)

    // One reading at a time: the block is busy right after it takes one.
    `LAC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_valid && i_s_ready, !i_s_ready)

endmodule

bind lux_autorange_converter_top lac_checker u_lac_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (s_axis_tvalid),
    .i_s_ready (s_axis_tready),
    .i_m_valid (m_axis_tvalid),
    .i_m_data  (m_axis_tdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    // Independent copies of the converter's constants.
    localparam int unsigned RAISE_LIMIT   = 6;
    localparam logic [7:0]  SETTING_HOME  = 8'd218;
    localparam int unsigned SETTING_CEIL  = 250;
    localparam logic [21:0] LUX_FULL      = 22'h3FFFFF;
    localparam int          DRAIN_CYCLES  = 50;
    localparam int          PHASE_ITEMS   = 155;
    localparam int          PHASE_COUNT   = 7;

    localparam int unsigned RATIO_EDGE [4] = '{26, 55, 109, 213};
    localparam int unsigned VIS_WEIGHT [4] = '{1290, 795, 510, 276};
    localparam int unsigned IR_WEIGHT  [4] = '{2733, 859, 345, 130};
    localparam int unsigned GAIN_OF    [4] = '{1, 2, 64, 128};

    typedef struct packed {
        logic        ok;
        logic [15:0] ir;
        logic [15:0] vis;
    } t_reading;

    typedef struct {
        lac_pkg::t_status status;
        logic [7:0]       next_setting;
        logic [21:0]      lux;
    } t_lux_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // [15:0] visible_count, [31:16] infrared_count
    logic        s_axis_tuser = 1'b0;  // [0] read_ok
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // [1:0] status, [9:2] next_setting, [31:10] lux

    // Predictor state and configuration shadow.
    logic [15:0] cfg_threshold = 16'd50000;
    logic [7:0]  cfg_setting_max = 8'd250;
    logic [5:0]  cfg_period = 6'd28;
    logic [1:0]  cfg_gain = 2'd0;
    logic [7:0]  cur_setting = SETTING_HOME;
    int unsigned raise_cnt = 0;

    t_reading    reading_q [$];
    t_lux_result pending_results [$];
    t_reading    next_reading;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          stall_enable = 1'b1;
    int          error_count = 0;
    int          phase_items = 0;

    lux_autorange_converter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Lux from one reading at the given integration setting, exact integer math.
    function automatic logic [21:0] lux_from_counts(logic [15:0] vis, logic [15:0] ir,
                                                    logic [7:0] setting);
        int unsigned band;
        int          b;
        logic [63:0] pos, neg, num, den, quo;
        if (vis == 0 || ir == 0) begin
            return '0;
        end
        band = 4;
        for (b = 3; b >= 0; b--) begin
            if (64'(ir) * 100 < 64'(vis) * RATIO_EDGE[b]) begin
                band = b;
            end
        end
        // Ratio at or above the top band edge gives no lux.
        if (band == 4) begin
            return '0;
        end
        pos = 64'(vis) * VIS_WEIGHT[band];
        neg = 64'(ir) * IR_WEIGHT[band];
        if (pos <= neg) begin
            return '0;
        end
        num = (pos - neg) * 1026;
        den = 64'(GAIN_OF[cfg_gain]) * cfg_period * 964 * (256 - setting);
        if (den == 0) begin
            return LUX_FULL;
        end
        quo = num / den;
        return (quo > 64'(LUX_FULL)) ? LUX_FULL : quo[21:0];
    endfunction

    // Expected result of one accepted reading; advances the autorange state.
    function automatic t_lux_result convert_reading(logic [15:0] vis, logic [15:0] ir,
                                                    logic ok);
        t_lux_result res;
        int unsigned gap;
        int unsigned nxt;
        res.lux = '0;
        if (!ok) begin
            res.status       = lac_pkg::STATUS_ERROR;
            res.next_setting = SETTING_HOME;
            cur_setting      = SETTING_HOME;
            raise_cnt        = 0;
        end else if ((vis > cfg_threshold || ir > cfg_threshold)
                     && raise_cnt < RAISE_LIMIT) begin
            gap = (cfg_setting_max > cur_setting) ? (cfg_setting_max - cur_setting) >> 1 : 0;
            nxt = (cur_setting + gap + 1) & 8'hFF;
            if (nxt > SETTING_CEIL) begin
                nxt = cfg_setting_max;
            end
            cur_setting      = nxt[7:0];
            raise_cnt        = raise_cnt + 1;
            res.status       = lac_pkg::STATUS_RAISE;
            res.next_setting = cur_setting;
        end else begin
            res.status       = lac_pkg::STATUS_LUX;
            res.next_setting = SETTING_HOME;
            res.lux          = lux_from_counts(vis, ir, cur_setting);
            cur_setting      = SETTING_HOME;
            raise_cnt        = 0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    // Sender: feeds queued readings, with random gaps while idling is enabled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (reading_q.size() != 0 && stall_enable && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end else if (reading_q.size() != 0) begin
                next_reading = reading_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_reading.ir, next_reading.vis};
                s_axis_tuser  <= next_reading.ok;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready, with random stall bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_enable && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check each result against the oldest expectation, then predict
    // the item accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with none pending", m_axis_tdata, 0);
                end else begin
                    t_lux_result want;
                    want = pending_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                        report_mismatch("status", m_axis_tdata[1:0], want.status);
                    if (m_axis_tdata[9:2] !== want.next_setting)
                        report_mismatch("next_setting", m_axis_tdata[9:2], want.next_setting);
                    if (m_axis_tdata[31:10] !== want.lux)
                        report_mismatch("lux", m_axis_tdata[31:10], want.lux);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(convert_reading(s_axis_tdata[15:0],
                                                          s_axis_tdata[31:16], s_axis_tuser));
            end
        end
    end

    task automatic queue_reading(logic [15:0] vis, logic [15:0] ir, logic ok);
        t_reading r;
        r.vis = vis;
        r.ir  = ir;
        r.ok  = ok;
        reading_q.push_back(r);
        phase_items++;
    endtask

    // Counts up to cap, mostly spread over the ratio bands.
    task automatic pick_counts(int unsigned cap, output logic [15:0] vis,
                               output logic [15:0] ir);
        int unsigned v, i, r;
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, cap);
                i = $urandom_range(0, cap);
            end
            1: begin
                v = $urandom_range(0, (cap < 3) ? cap : 3);
                i = $urandom_range(0, (cap < 3) ? cap : 3);
            end
            default: begin
                v = (cap == 0) ? 0 : $urandom_range(1, cap);
                if ($urandom_range(0, 1) && v > 2000) begin
                    v = $urandom_range(1, 2000);
                end
                r = $urandom_range(0, 230);
                i = (v * r + $urandom_range(0, 99)) / 100;
                if (i > cap) begin
                    i = cap;
                end
            end
        endcase
        vis = v[15:0];
        ir  = i[15:0];
    endtask

    // One autorange session: a run of bright readings, then a final one;
    // some sessions are plain noise or carry a failed reading.
    task automatic queue_session();
        int unsigned n_bright, k;
        logic [15:0] v, i;
        if ($urandom_range(0, 3) == 0) begin
            queue_reading(16'($urandom), 16'($urandom), $urandom_range(0, 7) != 0);
        end else begin
            n_bright = (cfg_threshold != 16'hFFFF) ? $urandom_range(0, 7) : 0;
            for (k = 0; k < n_bright; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    queue_reading(16'($urandom), 16'($urandom), 1'b0);
                end
                pick_counts(16'hFFFF, v, i);
                if ($urandom_range(0, 1)) begin
                    v = 16'($urandom_range(int'(cfg_threshold) + 1, 65535));
                end else begin
                    i = 16'($urandom_range(int'(cfg_threshold) + 1, 65535));
                end
                queue_reading(v, i, 1'b1);
            end
            pick_counts(cfg_threshold, v, i);
            queue_reading(v, i, $urandom_range(0, 19) != 0);
        end
    endtask

    task automatic cfg_write(lac_pkg::t_cfg_index idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            lac_pkg::CFG_RAISE_THRESHOLD: cfg_threshold   = val;
            lac_pkg::CFG_SETTING_MAX:     cfg_setting_max = val[7:0];
            lac_pkg::CFG_CLOCK_PERIOD:    cfg_period      = val[5:0];
            lac_pkg::CFG_GAIN_CODE:       cfg_gain        = val[1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [15:0] thr, logic [7:0] smax, logic [5:0] period,
                                  logic [1:0] gain);
        cfg_write(lac_pkg::CFG_RAISE_THRESHOLD, thr);
        cfg_write(lac_pkg::CFG_SETTING_MAX, 16'(smax));
        cfg_write(lac_pkg::CFG_CLOCK_PERIOD, 16'(period));
        cfg_write(lac_pkg::CFG_GAIN_CODE, 16'(gain));
    endtask

    // Look between edges so the queues and handshakes have settled.
    task automatic wait_drained();
        while (reading_q.size() != 0 || s_axis_tvalid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence: reset, directed readings at reset settings, then phases
    // of random sessions under varied settings.
    initial begin
        int p;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero counts, each ratio band, band edges and a non-positive numerator.
        queue_reading(16'd0, 16'd0, 1'b1);
        queue_reading(16'd1000, 16'd0, 1'b1);
        queue_reading(16'd0, 16'd1000, 1'b1);
        queue_reading(16'd1000, 16'd100, 1'b1);
        queue_reading(16'd1000, 16'd260, 1'b1);
        queue_reading(16'd1000, 16'd550, 1'b1);
        queue_reading(16'd1000, 16'd1090, 1'b1);
        queue_reading(16'd1000, 16'd2125, 1'b1);
        queue_reading(16'd130, 16'd276, 1'b1);
        queue_reading(16'd1000, 16'd2130, 1'b1);
        queue_reading(16'd50000, 16'd50000, 1'b1);
        // Failed readings.
        queue_reading(16'd0, 16'd0, 1'b0);
        queue_reading(16'hFFFF, 16'hFFFF, 1'b0);
        // Full raise chain up to the clamp, then a forced lux result.
        repeat (7) queue_reading(16'hFFFF, 16'd1, 1'b1);
        // Raises broken off by a failed reading, then a short session.
        repeat (2) queue_reading(16'd1, 16'hFFFF, 1'b1);
        queue_reading(16'd1, 16'hFFFF, 1'b0);
        queue_reading(16'd50001, 16'd100, 1'b1);
        queue_reading(16'd1, 16'd1, 1'b1);
        wait_drained();

        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: apply_settings(16'd50000, 8'd250, 6'd28, 2'd0);
                1: apply_settings(16'd0, 8'd255, 6'd63, 2'd3);
                2: apply_settings(16'hFFFF, 8'd219, 6'd1, 2'd0);
                3: apply_settings(16'd1000, 8'd250, 6'd0, 2'd1);
                4: apply_settings(16'($urandom), 8'd100, 6'($urandom_range(1, 63)), 2'd2);
                5: apply_settings(16'd40000, 8'($urandom_range(219, 255)), 6'd28, 2'd0);
                default: begin
                    // Last phase runs without any idling on either side.
                    stall_enable = 1'b0;
                    apply_settings(16'($urandom), 8'($urandom), 6'($urandom), 2'($urandom));
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                queue_session();
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #1000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
